### rtl/core/pla_pkg.sv
// shared types and constants for the page linear allocator
package pla_pkg;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_REALLOC = 2'd2,
        MODE_EMPTY   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SPACE    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    localparam logic [1:0] REG_PAGE_SHIFT   = 2'd0;
    localparam logic [1:0] REG_REGION_PAGES = 2'd1;
    localparam logic [1:0] REG_HEADER_PAGES = 2'd2;

    localparam logic [20:0] NEXT_MAX = 21'h1FFFFF;

endpackage

### rtl/core/page_linear_allocator_top.sv
// page linear allocator: bump allocator with an entry table scanned by a sequencer
// free and reallocate scan the entry table one entry at a time through its single read port
// (find pass, page-above pass, highest-page pass); allocate and empty do not scan it;
// a stalled output holds the result and delays the next request
// throughput: one request at a time, the next request is taken once the result leaves
// reset: asynchronous active low; entry count cleared, next-free set to header_pages,
// registers to defaults; the table itself is not cleared
module page_linear_allocator_top #(
    parameter int MAX_ENTRIES     = 1024,
    parameter int PAGE_INDEX_BITS = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 mode,
    input  logic [31:0]                byte_count,
    input  logic [19:0]                alloc_page,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [19:0]                result_page,
    output logic [1:0]                 status
);
    import pla_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [20:0] PLIM = (PAGE_INDEX_BITS >= 20) ? 21'h100000
                                   : 21'(64'd1 << PAGE_INDEX_BITS);
    localparam logic [CW-1:0] CMAX = CW'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_FIND_RD, S_FIND, S_ROOM, S_LAST_RD, S_LAST,
        S_ALLOC, S_REMOVE, S_MOVE, S_HI_RD, S_HI, S_HI_DONE, S_OUT
    } state_t;

    logic [4:0]  shift_reg;
    logic [20:0] region_reg;
    logic [4:0]  header_reg;

    logic [19:0] tpage [MAX_ENTRIES];
    logic [31:0] tbytes [MAX_ENTRIES];
    logic [19:0] rd_page_reg;
    logic [31:0] rd_bytes_reg;

    state_t      state_reg;
    logic [CW-1:0] count_reg;
    logic [20:0] next_reg;
    logic [1:0]  mode_reg;
    logic [31:0] bytes_reg;
    logic [19:0] page_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] scan_reg;
    logic [19:0] hi_page_reg;
    logic [31:0] hi_bytes_reg;
    logic        last_reg;
    logic        realloc_move_reg;
    logic [19:0] res_reg;
    logic [1:0]  st_reg;
    logic        out_valid_reg;

    logic [4:0]  eff_shift;
    logic [20:0] eff_header;
    logic [20:0] eff_region;
    logic [32:0] pg_in;
    logic [23:0] pg_out;
    logic [47:0] room;
    logic [24:0] alloc_end;
    logic [24:0] sum_next;

    always_comb
    begin
        eff_shift  = (shift_reg < 5'd9) ? 5'd9 : ((shift_reg > 5'd16) ? 5'd16 : shift_reg);
        eff_header = (header_reg < 5'd1) ? 21'd1
                   : ((header_reg > 5'd16) ? 21'd16 : {16'd0, header_reg});
        eff_region = (region_reg < 21'd1) ? 21'd1 : ((region_reg > PLIM) ? PLIM : region_reg);
    end

    // shared page-count unit: ceil(bytes / 2**shift)
    always_comb
    begin
        logic [31:0] src;
        logic [32:0] mask;
        case (state_reg)
            S_HI_DONE: src = hi_bytes_reg;
            S_ROOM:    src = rd_bytes_reg;
            default:   src = bytes_reg;
        endcase
        mask   = (33'd1 << eff_shift) - 33'd1;
        pg_in  = {1'b0, src} + mask;
        pg_out = 24'(pg_in >> eff_shift);
    end

    assign room      = 48'(pg_out) << eff_shift;
    assign alloc_end = {4'd0, next_reg} + {1'b0, pg_out} + 25'd1;
    assign sum_next  = (state_reg == S_HI_DONE) ? {5'd0, hi_page_reg} + {1'b0, pg_out}
                                                : {5'd0, page_reg} + {1'b0, pg_out};

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_page = res_reg;
    assign status      = st_reg;
    assign pready      = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_PAGE_SHIFT:   prdata = {27'd0, shift_reg};
            REG_REGION_PAGES: prdata = {11'd0, region_reg};
            REG_HEADER_PAGES: prdata = {27'd0, header_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= 5'd12;
            region_reg <= 21'h100000;
            header_reg <= 5'd2;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_PAGE_SHIFT:   shift_reg  <= pwdata[4:0];
                REG_REGION_PAGES: region_reg <= pwdata[20:0];
                REG_HEADER_PAGES: header_reg <= pwdata[4:0];
                default:          ;
            endcase
        end
    end

    // table write and registered read
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [19:0]   wr_page;
    logic [31:0]   wr_bytes;
    logic [IW-1:0] rd_addr;

    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_page  = rd_page_reg;
        wr_bytes = bytes_reg;
        rd_addr  = scan_reg;
        if (state_reg == S_ALLOC && alloc_end <= {4'd0, eff_region} && count_reg < CMAX)
        begin
            wr_en    = 1'b1;
            wr_addr  = count_reg[IW-1:0];
            wr_page  = 20'(next_reg + 21'd1);
        end
        else if (state_reg == S_ROOM && room >= {16'd0, bytes_reg})
        begin
            wr_en   = 1'b1;
            wr_page = page_reg;
        end
        else if (state_reg == S_LAST && last_reg && !(rd_page_reg > page_reg)
                 && CW'(scan_reg) == CW'(count_reg - 1'b1)
                 && sum_next <= {4'd0, eff_region})
        begin
            wr_en   = 1'b1;
            wr_page = page_reg;
        end
        else if (state_reg == S_MOVE)
        begin
            // last entry moved into freed slot; rd regs hold last entry
            wr_en    = (idx_reg != count_reg[IW-1:0]);
            wr_page  = rd_page_reg;
            wr_bytes = rd_bytes_reg;
        end
        if (state_reg == S_REMOVE)
            rd_addr = IW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tpage[wr_addr]  <= wr_page;
            tbytes[wr_addr] <= wr_bytes;
        end
        rd_page_reg  <= tpage[rd_addr];
        rd_bytes_reg <= tbytes[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            next_reg         <= {16'd0, 5'd2};
            out_valid_reg    <= 1'b0;
            mode_reg         <= 2'd0;
            bytes_reg        <= '0;
            page_reg         <= '0;
            idx_reg          <= '0;
            scan_reg         <= '0;
            hi_page_reg      <= '0;
            hi_bytes_reg     <= '0;
            last_reg         <= 1'b0;
            realloc_move_reg <= 1'b0;
            res_reg          <= '0;
            st_reg           <= ST_OK;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg         <= mode;
                        bytes_reg        <= byte_count;
                        page_reg         <= alloc_page;
                        res_reg          <= '0;
                        st_reg           <= ST_OK;
                        realloc_move_reg <= 1'b0;
                        state_reg        <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    scan_reg <= '0;
                    last_reg <= 1'b1;
                    case (mode_t'(mode_reg))
                        MODE_ALLOC: state_reg <= S_ALLOC;
                        MODE_FREE:
                            state_reg <= (page_reg == '0) ? S_OUT
                                       : ((count_reg == '0) ? S_OUT : S_FIND_RD);
                        MODE_REALLOC:
                            state_reg <= (page_reg == '0) ? S_ALLOC
                                       : ((count_reg == '0) ? S_OUT : S_FIND_RD);
                        default:
                        begin
                            count_reg <= '0;
                            next_reg  <= eff_header;
                            state_reg <= S_OUT;
                        end
                    endcase
                    if ((mode_reg == MODE_FREE || mode_reg == MODE_REALLOC)
                        && page_reg != '0 && count_reg == '0)
                        st_reg <= ST_NOTFOUND;
                end
                S_FIND_RD: state_reg <= S_FIND;
                S_FIND:
                begin
                    if (rd_page_reg == page_reg)
                    begin
                        idx_reg <= scan_reg;
                        if (mode_reg == MODE_FREE || bytes_reg == '0)
                            state_reg <= S_REMOVE;
                        else
                        begin
                            scan_reg  <= '0;
                            state_reg <= S_LAST_RD;
                        end
                    end
                    else if (CW'(scan_reg) == CW'(count_reg - 1'b1))
                    begin
                        st_reg    <= ST_NOTFOUND;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_FIND_RD;
                    end
                end
                S_LAST_RD: state_reg <= S_LAST;
                S_LAST:
                begin
                    // scanning for any page above ours
                    if (last_reg && rd_page_reg > page_reg)
                    begin
                        last_reg  <= 1'b0;
                        scan_reg  <= idx_reg;
                        state_reg <= S_LAST_RD;
                    end
                    else if (!last_reg)
                        state_reg <= S_ROOM;
                    else if (CW'(scan_reg) != CW'(count_reg - 1'b1))
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_LAST_RD;
                    end
                    else
                    begin
                        if (sum_next > {4'd0, eff_region})
                            st_reg <= ST_SPACE;
                        else
                        begin
                            res_reg  <= page_reg;
                            next_reg <= sum_next[20:0];
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_ROOM:
                begin
                    if (room >= {16'd0, bytes_reg})
                    begin
                        res_reg   <= page_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        realloc_move_reg <= 1'b1;
                        state_reg        <= S_ALLOC;
                    end
                end
                S_ALLOC:
                begin
                    if (alloc_end > {4'd0, eff_region})
                    begin
                        st_reg    <= ST_SPACE;
                        state_reg <= S_OUT;
                    end
                    else if (count_reg >= CMAX)
                    begin
                        st_reg    <= ST_FULL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        res_reg   <= 20'(next_reg + 21'd1);
                        count_reg <= count_reg + 1'b1;
                        next_reg  <= (alloc_end > {4'd0, NEXT_MAX}) ? NEXT_MAX
                                                                    : alloc_end[20:0];
                        state_reg <= realloc_move_reg ? S_REMOVE : S_OUT;
                    end
                end
                S_REMOVE:
                begin
                    count_reg <= count_reg - 1'b1;
                    if (count_reg == CW'(1))
                    begin
                        next_reg  <= eff_header;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_MOVE;
                end
                S_MOVE:
                begin
                    scan_reg  <= '0;
                    state_reg <= S_HI_RD;
                end
                S_HI_RD: state_reg <= S_HI;
                S_HI:
                begin
                    if (scan_reg == '0 || rd_page_reg > hi_page_reg)
                    begin
                        hi_page_reg  <= rd_page_reg;
                        hi_bytes_reg <= rd_bytes_reg;
                    end
                    if (CW'(scan_reg) == CW'(count_reg - 1'b1))
                        state_reg <= S_HI_DONE;
                    else
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_HI_RD;
                    end
                end
                S_HI_DONE:
                begin
                    next_reg  <= (sum_next > {4'd0, NEXT_MAX}) ? NEXT_MAX : sum_next[20:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                        out_valid_reg <= 1'b1;
                    else if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        hi_page_reg   <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CMAX)
        else $error("entry count above table depth");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(res_reg))
        else $error("stalled result changed");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_OUT)
        else $error("result shown outside output state");
`endif

endmodule
